>>> hw/rtl/adc_cal_pkg.sv
`default_nettype none
package adc_cal_pkg;

    localparam int CH_W       = 3;
    localparam int CODE_W     = 16;
    localparam int CNT_W      = 8;
    localparam int SUM_W      = 24;
    localparam int MVR_W      = 12;
    localparam int MV_W       = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // divider: |dc*dv| + den/2 stays below 2^29; divisors stay below 2^16
    localparam int DIV_W  = 29;
    localparam int DVS_W  = 16;
    localparam int MULA_W = 17;
    localparam int PROD_W = 29;

    localparam int FIFO_DEPTH = 2;

    localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 8'd1;
    localparam logic [MVR_W-1:0] FULLSCALE_MV_RST = 12'd2113;
    localparam logic [MVR_W-1:0] REFERENCE_MV_RST = 12'd894;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_COUNT = 2'd0,
        REG_FULLSCALE_MV = 2'd1,
        REG_REFERENCE_MV = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic             is_cal;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] taken;
    } job_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

endpackage
`default_nettype wire

>>> hw/rtl/adc_average_two_point_calibration_top.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready   | func, channel, raw_code
// out     | output    | out_valid/out_ready | out_channel, average_code, millivolts,
//         |           |                     | used_two_point, was_calibration
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Samples are taken one per cycle; only the item closing a burst waits for a queue slot.
// The back end's time per burst is set by the shared one-bit-per-cycle divider, used twice
// per normal burst and once per calibration burst; the 2-entry job queue
// lets the next burst's samples flow while the back end works.
// Reset is asynchronous; the reference table is cleared by reset, no clearing pass.
// A finished result waits in the output register while the back end starts the next job.
`default_nettype none
module adc_average_two_point_calibration_top #(
    parameter int WARMUP_SAMPLES = 16,
    parameter int CHANNELS       = 8,
    parameter int FULLSCALE_CODE = 1024
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic                                     func,
    input  wire logic [adc_cal_pkg::CH_W-1:0]             channel,
    input  wire logic [adc_cal_pkg::CODE_W-1:0]           raw_code,
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic [adc_cal_pkg::CH_W-1:0]                  out_channel,
    output logic [adc_cal_pkg::CODE_W-1:0]                average_code,
    output logic signed [adc_cal_pkg::MV_W-1:0]           millivolts,
    output logic                                          used_two_point,
    output logic                                          was_calibration,
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [adc_cal_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [adc_cal_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [adc_cal_pkg::CNT_W-1:0]  sample_count_reg;
    logic [adc_cal_pkg::MVR_W-1:0]  fullscale_mv_reg;
    logic [adc_cal_pkg::MVR_W-1:0]  reference_mv_reg;

    logic                           job_full;
    logic                           job_push;
    logic                           job_pop;
    logic                           job_valid;
    adc_cal_pkg::job_t              job_in;
    adc_cal_pkg::job_t              job_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= adc_cal_pkg::SAMPLE_COUNT_RST;
            fullscale_mv_reg <= adc_cal_pkg::FULLSCALE_MV_RST;
            reference_mv_reg <= adc_cal_pkg::REFERENCE_MV_RST;
        end
        else if (cfg_valid)
        begin
            case (adc_cal_pkg::cfg_reg_e'(cfg_index))
                adc_cal_pkg::REG_SAMPLE_COUNT:
                begin
                    sample_count_reg <= cfg_data[adc_cal_pkg::CNT_W-1:0];
                end
                adc_cal_pkg::REG_FULLSCALE_MV:
                begin
                    fullscale_mv_reg <= cfg_data;
                end
                adc_cal_pkg::REG_REFERENCE_MV:
                begin
                    reference_mv_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    adc_cal_front #(
        .WARMUP_SAMPLES (WARMUP_SAMPLES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .channel      (channel),
        .raw_code     (raw_code),
        .sample_count (sample_count_reg),
        .job_full     (job_full),
        .job_push     (job_push),
        .job          (job_in)
    );

    adc_cal_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .not_empty (job_valid)
    );

    adc_cal_back #(
        .CHANNELS       (CHANNELS),
        .FULLSCALE_CODE (FULLSCALE_CODE)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (job_valid),
        .job             (job_out),
        .job_pop         (job_pop),
        .fullscale_mv    (fullscale_mv_reg),
        .reference_mv    (reference_mv_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_channel     (out_channel),
        .average_code    (average_code),
        .millivolts      (millivolts),
        .used_two_point  (used_two_point),
        .was_calibration (was_calibration)
    );

endmodule
`default_nettype wire

>>> hw/rtl/adc_cal_front.sv
`default_nettype none
module adc_cal_front #(
    parameter int WARMUP_SAMPLES = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                func,
    input  wire logic [adc_cal_pkg::CH_W-1:0]        channel,
    input  wire logic [adc_cal_pkg::CODE_W-1:0]      raw_code,
    input  wire logic [adc_cal_pkg::CNT_W-1:0]       sample_count,
    input  wire logic                                job_full,
    output logic                                     job_push,
    output adc_cal_pkg::job_t                        job
);

    localparam int PW = $clog2(WARMUP_SAMPLES + 256);
    localparam logic [PW-1:0] WARM = PW'(WARMUP_SAMPLES);

    logic [PW-1:0]                     pos_reg, pos_next;
    logic [adc_cal_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [adc_cal_pkg::CH_W-1:0]      ch_reg, ch_next;
    logic                              cal_reg, cal_next;

    logic                              first;
    logic                              is_warm;
    logic                              burst_end;
    logic                              accept;
    logic [PW-1:0]                     taken_full;
    logic [adc_cal_pkg::CNT_W-1:0]     taken;
    logic [adc_cal_pkg::CNT_W-1:0]     want;
    logic [adc_cal_pkg::SUM_W-1:0]     sum_add;

    always_comb
    begin
        first      = (pos_reg == '0);
        is_warm    = (pos_reg < WARM);
        taken_full = pos_reg - WARM + PW'(1);
        taken      = taken_full[adc_cal_pkg::CNT_W-1:0];
        want       = (sample_count == '0) ? adc_cal_pkg::CNT_W'(1) : sample_count;
        burst_end  = !is_warm && (taken >= want);
        // only the item that closes a burst needs room in the queue
        in_ready   = !(burst_end && job_full);
        accept     = in_valid && in_ready;
        sum_add    = sum_reg + adc_cal_pkg::SUM_W'(raw_code);

        ch_next  = first ? channel : ch_reg;
        cal_next = first ? func : cal_reg;
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            if (is_warm)
            begin
                pos_next = pos_reg + PW'(1);
            end
            else if (burst_end)
            begin
                pos_next = '0;
                sum_next = '0;
            end
            else
            begin
                pos_next = pos_reg + PW'(1);
                sum_next = sum_add;
            end
        end

        job_push     = accept && burst_end;
        job.channel  = ch_next;
        job.is_cal   = cal_next;
        job.sum      = sum_add;
        job.taken    = taken;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
            ch_reg  <= '0;
            cal_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            if (accept)
            begin
                ch_reg  <= ch_next;
                cal_reg <= cal_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/adc_cal_fifo.sv
`default_nettype none
module adc_cal_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  adc_cal_pkg::job_t   push_data,
    output logic                full,
    input  wire logic           pop,
    output adc_cal_pkg::job_t   pop_data,
    output logic                not_empty
);

    localparam int DEPTH = adc_cal_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    adc_cal_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    always_comb
    begin
        full      = (count_reg == CNT_W'(DEPTH));
        not_empty = (count_reg != '0);
        pop_data  = mem_reg[rd_ptr_reg];
        do_push   = push && !full;
        do_pop    = pop && not_empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/adc_cal_div.sv
`default_nettype none
module adc_cal_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  adc_cal_pkg::div_req_t                  req,
    output logic                                   done,
    output logic [adc_cal_pkg::DIV_W-1:0]          quotient
);

    localparam int DW = adc_cal_pkg::DIV_W;
    localparam int VW = adc_cal_pkg::DVS_W;
    localparam int SW = $clog2(DW);

    logic            busy_reg;
    logic            done_reg;
    logic [SW-1:0]   step_reg;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [VW-1:0]   dvs_reg;
    logic [VW:0]     shifted;
    logic [VW:0]     diff;
    logic            ge;

    // restoring division, one quotient bit per cycle, MSB first
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? diff[VW-1:0] : shifted[VW-1:0];
        quo_next = {quo_reg[DW-2:0], ge};
        done     = done_reg;
        quotient = quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= SW'(DW - 1);
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - SW'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/adc_cal_back.sv
`default_nettype none
module adc_cal_back #(
    parameter int CHANNELS       = 8,
    parameter int FULLSCALE_CODE = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  job_valid,
    input  adc_cal_pkg::job_t                          job,
    output logic                                       job_pop,
    input  wire logic [adc_cal_pkg::MVR_W-1:0]         fullscale_mv,
    input  wire logic [adc_cal_pkg::MVR_W-1:0]         reference_mv,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [adc_cal_pkg::CH_W-1:0]               out_channel,
    output logic [adc_cal_pkg::CODE_W-1:0]             average_code,
    output logic signed [adc_cal_pkg::MV_W-1:0]        millivolts,
    output logic                                       used_two_point,
    output logic                                       was_calibration
);

    localparam int CW = adc_cal_pkg::CODE_W;
    localparam int VW = adc_cal_pkg::DVS_W;
    localparam int MW = adc_cal_pkg::MV_W;
    localparam int AW = adc_cal_pkg::MULA_W;
    localparam int BW = adc_cal_pkg::MVR_W;
    localparam logic [CW-1:0] FS = CW'(FULLSCALE_CODE);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_AVG,
        ST_PREP,
        ST_MUL,
        ST_LOAD_MV,
        ST_DIV_MV,
        ST_EMIT
    } state_t;

    state_t                              state_reg;
    logic [adc_cal_pkg::CH_W-1:0]        ch_reg;
    logic                                cal_reg;
    logic [CW-1:0]                       avg_reg;
    logic                                tp_reg;
    logic                                neg_reg;
    logic [AW-1:0]                       mul_a_reg;
    logic [BW-1:0]                       mul_b_reg;
    logic [VW-1:0]                       den_reg;
    logic [adc_cal_pkg::PROD_W-1:0]      prod_reg;
    logic [MW-1:0]                       mv_reg;
    adc_cal_pkg::div_req_t               div_req_reg;

    logic                                out_valid_reg;
    logic [adc_cal_pkg::CH_W-1:0]        out_channel_reg;
    logic [CW-1:0]                       average_code_reg;
    logic [MW-1:0]                       millivolts_reg;
    logic                                used_two_point_reg;
    logic                                was_calibration_reg;

    logic [CW-1:0]                       ref_table_reg [CHANNELS];

    logic                                div_done;
    logic [adc_cal_pkg::DIV_W-1:0]       div_quo;
    logic [CW-1:0]                       ref_val;
    logic                                ref_ok;
    logic signed [AW-1:0]                dc;
    logic signed [BW:0]                  dv;
    logic [AW-1:0]                       dc_mag;
    logic [BW:0]                         dv_mag;
    logic [MW-1:0]                       q_ext;
    logic                                table_wr;
    logic                                out_free;

    adc_cal_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        ref_val = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if ({29'd0, ch_reg} == 32'(i))
            begin
                ref_val = ref_table_reg[i];
            end
        end
        ref_ok   = (ref_val != '0) && (ref_val < FS);
        dc       = AW'({1'b0, avg_reg}) - AW'({1'b0, ref_val});
        dv       = (BW + 1)'({1'b0, fullscale_mv}) - (BW + 1)'({1'b0, reference_mv});
        dc_mag   = dc[AW-1] ? AW'(-dc) : AW'(dc);
        dv_mag   = dv[BW] ? (BW + 1)'(-dv) : (BW + 1)'(dv);
        q_ext    = MW'(div_quo);
        table_wr = (state_reg == ST_PREP) && cal_reg;
        out_free = !out_valid_reg || out_ready;
        job_pop  = (state_reg == ST_IDLE) && job_valid;

        out_valid       = out_valid_reg;
        out_channel     = out_channel_reg;
        average_code    = average_code_reg;
        millivolts      = millivolts_reg;
        used_two_point  = used_two_point_reg;
        was_calibration = was_calibration_reg;
    end

    // channels at or above CHANNELS match no entry: stores drop, reads give zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                ref_table_reg[i] <= '0;
            end
        end
        else if (table_wr)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if ({29'd0, ch_reg} == 32'(i))
                begin
                    ref_table_reg[i] <= avg_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            div_req_reg         <= '0;
            out_valid_reg       <= 1'b0;
            ch_reg              <= '0;
            cal_reg             <= 1'b0;
            avg_reg             <= '0;
            tp_reg              <= 1'b0;
            neg_reg             <= 1'b0;
            mul_a_reg           <= '0;
            mul_b_reg           <= '0;
            den_reg             <= '0;
            prod_reg            <= '0;
            mv_reg              <= '0;
            out_channel_reg     <= '0;
            average_code_reg    <= '0;
            millivolts_reg      <= '0;
            used_two_point_reg  <= 1'b0;
            was_calibration_reg <= 1'b0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        ch_reg               <= job.channel;
                        cal_reg              <= job.is_cal;
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= adc_cal_pkg::DIV_W'(job.sum);
                        div_req_reg.divisor  <= VW'(job.taken);
                        state_reg            <= ST_DIV_AVG;
                    end
                end
                ST_DIV_AVG:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= div_quo[CW-1:0];
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    if (cal_reg)
                    begin
                        tp_reg    <= 1'b0;
                        mv_reg    <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        tp_reg    <= ref_ok;
                        neg_reg   <= ref_ok && (dc[AW-1] ^ dv[BW]);
                        mul_a_reg <= ref_ok ? dc_mag : AW'(avg_reg);
                        mul_b_reg <= ref_ok ? dv_mag[BW-1:0] : fullscale_mv;
                        den_reg   <= ref_ok ? (FS - ref_val) : FS;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= adc_cal_pkg::PROD_W'(mul_a_reg * mul_b_reg);
                    state_reg <= ST_LOAD_MV;
                end
                ST_LOAD_MV:
                begin
                    // two-point rounds half away from zero on the magnitude
                    div_req_reg.start    <= 1'b1;
                    div_req_reg.dividend <= prod_reg +
                        (tp_reg ? adc_cal_pkg::DIV_W'(den_reg >> 1) : '0);
                    div_req_reg.divisor  <= den_reg;
                    state_reg            <= ST_DIV_MV;
                end
                ST_DIV_MV:
                begin
                    if (div_done)
                    begin
                        if (tp_reg)
                        begin
                            mv_reg <= MW'(reference_mv) + (neg_reg ? MW'(-q_ext) : q_ext);
                        end
                        else
                        begin
                            mv_reg <= q_ext;
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_channel_reg     <= ch_reg;
                        average_code_reg    <= avg_reg;
                        millivolts_reg      <= mv_reg;
                        used_two_point_reg  <= tp_reg;
                        was_calibration_reg <= cal_reg;
                        state_reg           <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/adc_cal_check.sv
`default_nettype none
module adc_cal_check (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_ready,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic [adc_cal_pkg::CH_W-1:0]         out_channel,
    input  wire logic [adc_cal_pkg::CODE_W-1:0]       average_code,
    input  wire logic signed [adc_cal_pkg::MV_W-1:0]  millivolts,
    input  wire logic                                 used_two_point,
    input  wire logic                                 was_calibration
);

    // a stalled result keeps its channel, average code and millivolts
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average_code)
            && $stable(millivolts) && $stable(out_channel))
        else $error("result changed while stalled");

    a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(used_two_point && was_calibration))
        else $error("calibration result flagged as two-point");

    a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_calibration |-> millivolts == '0)
        else $error("calibration result carries millivolts");

    a_gain_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !used_two_point |-> !millivolts[adc_cal_pkg::MV_W-1])
        else $error("gain-only result negative");

    a_fresh_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(rst_n))
        else $error("result right out of reset");

endmodule

bind adc_average_two_point_calibration_top adc_cal_check u_adc_cal_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .average_code    (average_code),
    .millivolts      (millivolts),
    .used_two_point  (used_two_point),
    .was_calibration (was_calibration)
);
`default_nettype wire
